### design/xs_pkg.sv
// Shared types and constants for the xoshiro256** generator.
package xs_pkg;

    // SplitMix64 constants
    localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;

    // xoshiro256** update shift and rotate
    localparam int unsigned XS_SHIFT  = 17;
    localparam int unsigned XS_ROTATE = 45;

    // Partial product phases of a 64x64 low-half multiply
    localparam logic [1:0] PH_LL = 2'd0;
    localparam logic [1:0] PH_LH = 2'd1;
    localparam logic [1:0] PH_HL = 2'd2;

    // Item kinds
    localparam logic KIND_SEED = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    // Control of the shared multiply-accumulate unit
    typedef struct packed {
        logic       en;
        logic [1:0] phase;
    } mac_ctrl_t;

endpackage

### design/xs_mac.sv
// Shared 32x32 multiply-accumulate unit that builds a 64-bit low-half product in three phases.
module xs_mac (
    input  logic              aclk,
    input  xs_pkg::mac_ctrl_t ctrl,
    input  logic [63:0]       op_a,
    input  logic [63:0]       op_b,
    output logic [63:0]       acc
);

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;

    // Pick the halves for this phase
    always_comb begin
        case (ctrl.phase)
            xs_pkg::PH_LL: begin
                mul_a = op_a[31:0];
                mul_b = op_b[31:0];
            end
            xs_pkg::PH_LH: begin
                mul_a = op_a[31:0];
                mul_b = op_b[63:32];
            end
            xs_pkg::PH_HL: begin
                mul_a = op_a[63:32];
                mul_b = op_b[31:0];
            end
            default: begin
                mul_a = op_a[31:0];
                mul_b = op_b[31:0];
            end
        endcase
    end

    assign prod = {32'h0, mul_a} * {32'h0, mul_b};

    // Start on the low product, then add cross terms into the upper half
    always_comb begin
        if (ctrl.phase == xs_pkg::PH_LL) begin
            acc_next = prod;
        end else begin
            acc_next = acc_reg + {prod[31:0], 32'h0};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

### design/xoshiro256ss_generator.sv
// Top level of the xoshiro256** word generator with SplitMix64 seeding.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------
//   s_      | s_valid / s_ready  | s_kind (1), s_seed (64)
//   m_      | m_valid / m_ready  | m_value (64)
//
// A draw runs from accept back to ready as one shift-add for w1*5, then
// one shift-add for the *9 together with the state update.
// A seed runs, per SplitMix64 word, one counter step, two three-phase
// multiplies on the shared 32x32 unit, one xor step and one store.
// After reset the block runs the seed-zero expansion and is not ready until it ends.
// A waiting result holds the draw in its last step; seeds proceed regardless.
module xoshiro256ss_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [63:0] s_seed,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MIX_ADD = 3'd1;
    localparam logic [2:0] ST_MUL_A   = 3'd2;
    localparam logic [2:0] ST_XOR_A   = 3'd3;
    localparam logic [2:0] ST_MUL_B   = 3'd4;
    localparam logic [2:0] ST_STORE   = 3'd5;
    localparam logic [2:0] ST_DRAW1   = 3'd6;
    localparam logic [2:0] ST_DRAW2   = 3'd7;

    logic [2:0]  state_reg;
    logic [1:0]  phase_reg;
    logic [1:0]  idx_reg;
    logic [63:0] counter_reg;
    logic [63:0] z_reg;
    logic [63:0] t_reg;
    logic [63:0] words_reg [4];
    logic        m_valid_reg;
    logic [63:0] m_value_reg;

    xs_pkg::mac_ctrl_t mac_ctrl;
    logic [63:0] mac_b;
    logic [63:0] acc;
    logic [63:0] counter_next;
    logic [63:0] rot_t;
    logic [63:0] w0_next;
    logic [63:0] w1_next;
    logic [63:0] w2_next;
    logic [63:0] w3_x;
    logic        out_free;
    logic        s_fire;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Drive the shared multiplier
    assign mac_ctrl.en    = (state_reg == ST_MUL_A) || (state_reg == ST_MUL_B);
    assign mac_ctrl.phase = phase_reg;
    assign mac_b          = (state_reg == ST_MUL_B) ? xs_pkg::MIX_MUL_B : xs_pkg::MIX_MUL_A;

    xs_mac u_mac (
        .aclk (aclk),
        .ctrl (mac_ctrl),
        .op_a (z_reg),
        .op_b (mac_b),
        .acc  (acc)
    );

    assign counter_next = counter_reg + xs_pkg::GOLDEN_STEP;

    // Draw datapath: rotate of w1*5, and the state update
    assign rot_t   = {t_reg[56:0], t_reg[63:57]};
    assign w2_next = words_reg[2] ^ words_reg[0] ^ (words_reg[1] << xs_pkg::XS_SHIFT);
    assign w3_x    = words_reg[3] ^ words_reg[1];
    assign w1_next = words_reg[1] ^ words_reg[2] ^ words_reg[0];
    assign w0_next = words_reg[0] ^ w3_x;

    // Sequence the seed expansion and draws
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_MIX_ADD;
            phase_reg   <= xs_pkg::PH_LL;
            idx_reg     <= 2'd0;
            counter_reg <= 64'h0;
            m_valid_reg <= 1'b0;
        end else begin
            // drop the output word once taken, unless the draw refills it
            if (m_valid_reg && m_ready && (state_reg != ST_DRAW2)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_kind == xs_pkg::KIND_SEED) begin
                            counter_reg <= s_seed;
                            idx_reg     <= 2'd0;
                            state_reg   <= ST_MIX_ADD;
                        end else begin
                            state_reg <= ST_DRAW1;
                        end
                    end
                end
                ST_MIX_ADD: begin
                    counter_reg <= counter_next;
                    z_reg       <= counter_next ^ (counter_next >> 30);
                    phase_reg   <= xs_pkg::PH_LL;
                    state_reg   <= ST_MUL_A;
                end
                ST_MUL_A, ST_MUL_B: begin
                    case (phase_reg)
                        xs_pkg::PH_LL: phase_reg <= xs_pkg::PH_LH;
                        xs_pkg::PH_LH: phase_reg <= xs_pkg::PH_HL;
                        default: begin
                            phase_reg <= xs_pkg::PH_LL;
                            state_reg <= (state_reg == ST_MUL_A) ? ST_XOR_A : ST_STORE;
                        end
                    endcase
                end
                ST_XOR_A: begin
                    z_reg     <= acc ^ (acc >> 27);
                    state_reg <= ST_MUL_B;
                end
                ST_STORE: begin
                    words_reg[idx_reg] <= acc ^ (acc >> 31);
                    idx_reg            <= idx_reg + 2'd1;
                    state_reg          <= (idx_reg == 2'd3) ? ST_IDLE : ST_MIX_ADD;
                end
                ST_DRAW1: begin
                    t_reg     <= words_reg[1] + (words_reg[1] << 2);
                    state_reg <= ST_DRAW2;
                end
                ST_DRAW2: begin
                    // hold until the output word is free
                    if (out_free) begin
                        m_value_reg  <= rot_t + (rot_t << 3);
                        m_valid_reg  <= 1'b1;
                        words_reg[0] <= w0_next;
                        words_reg[1] <= w1_next;
                        words_reg[2] <= w2_next;
                        words_reg[3] <= {w3_x[63-xs_pkg::XS_ROTATE:0],
                                         w3_x[63:64-xs_pkg::XS_ROTATE]};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

    // A new output word only comes from the last draw step
    a_valid_from_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_DRAW2)
        else $error("output word raised outside a draw");

    // The xor step only follows a full first multiply
    a_xor_after_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_XOR_A |-> $past(state_reg) == ST_MUL_A
                                  && $past(phase_reg) == xs_pkg::PH_HL)
        else $error("xor step entered before multiply finished");

    // A seed word restarts the expansion at the first state word
    a_seed_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_kind == xs_pkg::KIND_SEED |=> state_reg == ST_MIX_ADD && idx_reg == 2'd0)
        else $error("seed did not restart expansion");

    // A stalled output word is not overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(m_value_reg))
        else $error("waiting output word overwritten");

endmodule
